// ===== hw/rtl/cbm_pkg.sv =====
// cbm_pkg: shared types and constants of the cartridge bank mapper
// used by cbm_core and cartridge_bank_mapper; depends on nothing
package cbm_pkg;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_ROM,
    KIND_MBC1,
    KIND_MBC2,
    KIND_MBC3,
    KIND_MBC5
  } kind_t;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
  localparam logic [1:0] ST_BAD_ADDR    = 2'd2;

  localparam logic [7:0] NO_RAM = 8'hFF;

  typedef struct packed {
    logic       ram_enabled;
    logic       advanced_mode;
    logic [7:0] rom_bank_low;
    logic [1:0] rom_bank_upper;
    logic [7:0] ram_bank_number;
  } bank_state_t;

  localparam bank_state_t BANK_CLEAR = '0;

  typedef struct packed {
    logic [8:0] rom_bank;
    logic [7:0] ram_bank;
    logic [1:0] status;
  } result_t;

endpackage

// ===== hw/rtl/cbm_core.sv =====
// cbm_core: per-word bank register update and bank lookup
// combinational; depends on cbm_pkg
module cbm_core import cbm_pkg::*; (
  input  kind_t         kind,
  input  bank_state_t   state,
  input  logic          write_access,
  input  logic [15:0]   address,
  input  logic [7:0]    data,
  output bank_state_t   state_next,
  output result_t       result
);

  logic nibble_a;
  logic low_zero;

  assign nibble_a = (data[3:0] == 4'hA);

  // register writes
  always_comb begin
    state_next = state;
    if (write_access) begin
      case (kind)
        KIND_MBC1: begin
          if (address <= 16'h1FFF) state_next.ram_enabled = nibble_a;
          else if (address <= 16'h3FFF) state_next.rom_bank_low = {3'b0, data[4:0]};
          else if (address <= 16'h5FFF) state_next.rom_bank_upper = data[1:0];
          else if (address <= 16'h7FFF) state_next.advanced_mode = data[0];
        end
        KIND_MBC2: begin
          if (address <= 16'h3FFF) begin
            if (!address[8]) state_next.ram_enabled = nibble_a;
            else state_next.rom_bank_low = {4'b0, data[3:0]};
          end
          if (address >= 16'h2100 && address <= 16'h2FFF)
            state_next.rom_bank_low = {4'b0, data[3:0]};
        end
        KIND_MBC3: begin
          if (address <= 16'h1FFF) state_next.ram_enabled = (data == 8'h0A);
          else if (address <= 16'h3FFF) state_next.rom_bank_low = {1'b0, data[6:0]};
          else if (address <= 16'h5FFF) begin
            if (data <= 8'h07) state_next.ram_bank_number = data;
            else if (data <= 8'h0C) state_next.ram_bank_number = NO_RAM;  // clock select
          end
        end
        KIND_MBC5: begin
          if (address <= 16'h1FFF) state_next.ram_enabled = nibble_a;
          else if (address <= 16'h2FFF) state_next.rom_bank_low = data;
          else if (address <= 16'h3FFF) state_next.rom_bank_upper = {1'b0, data[0]};
          else if (address <= 16'h5FFF) state_next.ram_bank_number = data;
        end
        default: begin
        end
      endcase
    end
  end

  assign low_zero = (state_next.rom_bank_low == 8'h00);

  // bank lookup on the updated registers
  always_comb begin
    result.rom_bank = 9'd0;
    result.ram_bank = NO_RAM;
    result.status   = ST_OK;
    case (kind)
      KIND_ROM: begin
        result.rom_bank = (address < 16'h4000) ? 9'd0 : 9'd1;
      end
      KIND_MBC1: begin
        if (address <= 16'h3FFF) begin
          result.rom_bank = state_next.advanced_mode ?
                            {2'b0, state_next.rom_bank_upper, 5'b0} : 9'd0;
        end else if (address <= 16'h7FFF) begin
          result.rom_bank = ({1'b0, state_next.rom_bank_low}
                             | {2'b0, state_next.rom_bank_upper, 5'b0})
                            + {8'b0, low_zero};
        end else begin
          result.status = ST_BAD_ADDR;
        end
        if (state_next.ram_enabled)
          result.ram_bank = state_next.advanced_mode ?
                            {6'b0, state_next.rom_bank_upper} : 8'h00;
      end
      KIND_MBC2: begin
        if (address >= 16'h4000)
          result.rom_bank = low_zero ? 9'd1 : {1'b0, state_next.rom_bank_low};
      end
      KIND_MBC3: begin
        if (address >= 16'h8000) result.rom_bank = 9'd1;
        else if (address >= 16'h4000)
          result.rom_bank = low_zero ? 9'd1 : {1'b0, state_next.rom_bank_low};
        result.ram_bank = state_next.ram_bank_number;
      end
      KIND_MBC5: begin
        if (address >= 16'h4000)
          result.rom_bank = {state_next.rom_bank_upper[0], state_next.rom_bank_low};
        if (state_next.ram_enabled) result.ram_bank = state_next.ram_bank_number;
      end
      default: begin
        result.status = ST_UNSUPPORTED;
      end
    endcase
  end

endmodule

// ===== hw/rtl/cartridge_bank_mapper.sv =====
// cartridge_bank_mapper: top level of the cartridge bank mapper
// input word register, bank registers and result register; uses cbm_pkg and cbm_core
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------
//   in       | in_valid / in_stall  | write_access, address, data
//   out      | out_valid / out_stall| rom_bank, ram_bank, status
//   cfg      | cfg_valid / cfg_ready| cartridge_type
//
// one word per cycle while out_stall is low: a word is held in the input register,
// then the bank update and lookup run in cbm_core and land in the result register
// where out_valid rises as it loads, so a result word follows its access word
// through the input register and then the result register
// synchronous reset clears all valid flags and bank registers, kind is set as for type code 0
// out_stall holds the result register; in_stall rises at once when the input
// register is occupied too, an empty input register first takes one more word
module cartridge_bank_mapper import cbm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // bus access words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        write_access,
  input  logic [15:0] address,
  input  logic [7:0]  data,
  // bank results
  output logic        out_valid,
  input  logic        out_stall,
  output logic [8:0]  rom_bank,
  output logic [7:0]  ram_bank,
  output logic [1:0]  status,
  // cartridge type setup
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cartridge_type
);

  // header code to mapper family
  function automatic kind_t decode_kind(input logic [7:0] t);
    kind_t k;
    k = KIND_NONE;
    if (t == 8'h00) k = KIND_ROM;
    else if (t >= 8'h01 && t <= 8'h03) k = KIND_MBC1;
    else if (t >= 8'h05 && t <= 8'h06) k = KIND_MBC2;
    else if (t >= 8'h0F && t <= 8'h13) k = KIND_MBC3;
    else if (t >= 8'h19 && t <= 8'h1E) k = KIND_MBC5;
    return k;
  endfunction

  kind_t       kind;
  bank_state_t banks;
  bank_state_t banks_next;
  result_t     result;

  // input register
  logic        stage_valid;
  logic        stage_write;
  logic [15:0] stage_address;
  logic [7:0]  stage_data;

  logic take;        // result register can load this cycle
  logic stage_load;  // input register can load this cycle
  logic cfg_write;

  assign take       = !out_valid || !out_stall;
  assign stage_load = !stage_valid || take;
  assign in_stall   = !stage_load;
  assign cfg_ready  = 1'b1;
  assign cfg_write  = cfg_valid && cfg_ready;

  cbm_core u_core (
    .kind         (kind),
    .state        (banks),
    .write_access (stage_write),
    .address      (stage_address),
    .data         (stage_data),
    .state_next   (banks_next),
    .result       (result)
  );

  // input word register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (stage_load) begin
      stage_valid <= in_valid;
    end
    if (stage_load && in_valid) begin
      stage_write   <= write_access;
      stage_address <= address;
      stage_data    <= data;
    end
  end

  // mapper type and bank registers; a type write starts the mapper fresh
  always_ff @(posedge clk) begin
    if (rst) begin
      kind  <= KIND_ROM;
      banks <= BANK_CLEAR;
    end else if (cfg_write) begin
      kind  <= decode_kind(cartridge_type);
      banks <= BANK_CLEAR;
    end else if (take && stage_valid) begin
      banks <= banks_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= stage_valid;
    end
    if (take && stage_valid) begin
      rom_bank <= result.rom_bank;
      ram_bank <= result.ram_bank;
      status   <= result.status;
    end
  end

  // out-of-range mbc1 access reports bank zero
  a_bad_addr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_BAD_ADDR |-> rom_bank == 9'd0)
    else $error("bad address result with nonzero rom bank");

  // unsupported type never shows external ram and reports rom bank zero
  a_unsup_no_ram: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_UNSUPPORTED |-> ram_bank == NO_RAM && rom_bank == 9'd0)
    else $error("unsupported type result not blank");

  // type write clears every bank register
  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> banks == BANK_CLEAR)
    else $error("bank registers not cleared by type write");

  // stall only when a word is waiting in the input register
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> stage_valid && out_valid && out_stall)
    else $error("input stalled with room available");

  // reset empties both registers
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !stage_valid && !out_valid)
    else $error("valid flags survive reset");

endmodule
